@@ design/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the dose stepper sequencer
// Holds the micro-operation codes, the status bundle read by the sequencer
// and the widths of the shared serial divider.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int unsigned DivDendW = 27;  // widest dividend: progress * 100
  localparam int unsigned DivSorW  = 24;  // widest divisor: area * step length
  localparam int unsigned DivCntW  = 5;   // holds DivDendW

  localparam int unsigned StepsW = 20;
  localparam int unsigned DelayW = 10;
  localparam int unsigned PctW   = 7;

  // Command codes carried in the func field.
  localparam logic FuncStart = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // Register indexes on the configuration port.
  localparam logic RegPlungerArea = 1'b0;
  localparam logic RegStepLength  = 1'b1;

  // Micro-operations that a control word hands to the datapath.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_STEPS,
    OP_DIV_DELAY,
    OP_START,
    OP_TICK,
    OP_DIV_PCT,
    OP_SAVE_PCT,
    OP_EMIT
  } dss_op_e;

  // Datapath status that the jump conditions test.
  typedef struct packed {
    logic item_taken;  // an input transfer happens this cycle
    logic tick_cmd;    // latched command is a millisecond tick
    logic div_busy;    // divider still iterating
    logic out_hold;    // output register full and stalled
    logic no_steps;    // current move has no steps at all
  } dss_status_t;

endpackage

@@ design/dss_divider.sv @@
// ----------------------------------------------------------------------------
// dss_divider: restoring unsigned divider, one quotient bit per cycle
// A start pulse loads the operands; the quotient is valid once busy drops.
// ----------------------------------------------------------------------------
module dss_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dss_pkg::DivDendW-1:0]   dividend_i,
  input  logic [dss_pkg::DivSorW-1:0]    divisor_i,
  output logic                           busy_o,
  output logic [dss_pkg::DivDendW-1:0]   quotient_o
);
  import dss_pkg::*;

  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DivDendW-1:0] quo_q, quo_d;
  logic [DivSorW-1:0]  rem_q, rem_d;
  logic [DivSorW-1:0]  sor_q, sor_d;
  logic [DivSorW:0]    shifted;
  logic [DivSorW:0]    diff;
  logic                fits;

  assign shifted = {rem_q, quo_q[DivDendW-1]};
  assign diff    = shifted - {1'b0, sor_q};
  assign fits    = shifted >= {1'b0, sor_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    sor_d = sor_q;
    if (start_i) begin
      cnt_d = DivCntW'(DivDendW);
      quo_d = dividend_i;
      rem_d = '0;
      sor_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[DivDendW-2:0], fits};
      // The remainder stays below the divisor, so it fits the narrower width.
      rem_d = fits ? diff[DivSorW-1:0] : shifted[DivSorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    sor_q <= sor_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

@@ design/dss_sequencer.sv @@
// ----------------------------------------------------------------------------
// dss_sequencer: microprogram counter and control store
// Each step issues one micro-operation and an optional conditional jump.
// ----------------------------------------------------------------------------
module dss_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dss_pkg::dss_status_t status_i,
  output dss_pkg::dss_op_e     op_o
);
  import dss_pkg::*;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_ITEM,
    JC_TICK,
    JC_DIV_BUSY,
    JC_OUT_HOLD,
    JC_NO_STEPS
  } jump_cond_e;

  typedef struct packed {
    dss_op_e    op;
    jump_cond_e cond;
    logic [3:0] target;
  } ucode_word_t;

  localparam logic [3:0] PcWait     = 4'd0;
  localparam logic [3:0] PcWaitStep = 4'd3;
  localparam logic [3:0] PcWaitDly  = 4'd5;
  localparam logic [3:0] PcTick     = 4'd7;
  localparam logic [3:0] PcPct      = 4'd8;
  localparam logic [3:0] PcWaitPct  = 4'd9;
  localparam logic [3:0] PcOutWait  = 4'd11;

  function automatic ucode_word_t ucode_rom(input logic [3:0] pc);
    ucode_word_t w;
    unique case (pc)
      4'd0:    w = '{OP_ACCEPT,    JC_NO_ITEM,  PcWait};
      4'd1:    w = '{OP_NOP,       JC_TICK,     PcTick};
      4'd2:    w = '{OP_DIV_STEPS, JC_NEXT,     PcWait};
      4'd3:    w = '{OP_NOP,       JC_DIV_BUSY, PcWaitStep};
      4'd4:    w = '{OP_DIV_DELAY, JC_NEXT,     PcWait};
      4'd5:    w = '{OP_NOP,       JC_DIV_BUSY, PcWaitDly};
      4'd6:    w = '{OP_START,     JC_ALWAYS,   PcPct};
      4'd7:    w = '{OP_TICK,      JC_NEXT,     PcWait};
      4'd8:    w = '{OP_DIV_PCT,   JC_NO_STEPS, PcOutWait};
      4'd9:    w = '{OP_NOP,       JC_DIV_BUSY, PcWaitPct};
      4'd10:   w = '{OP_SAVE_PCT,  JC_NEXT,     PcWait};
      4'd11:   w = '{OP_NOP,       JC_OUT_HOLD, PcOutWait};
      4'd12:   w = '{OP_EMIT,      JC_ALWAYS,   PcWait};
      default: w = '{OP_NOP,       JC_ALWAYS,   PcWait};
    endcase
    return w;
  endfunction

  logic [3:0]  pc_q, pc_d;
  ucode_word_t word;
  logic        taken;

  assign word = ucode_rom(pc_q);

  always_comb begin
    unique case (word.cond)
      JC_NEXT:     taken = 1'b0;
      JC_ALWAYS:   taken = 1'b1;
      JC_NO_ITEM:  taken = !status_i.item_taken;
      JC_TICK:     taken = status_i.tick_cmd;
      JC_DIV_BUSY: taken = status_i.div_busy;
      JC_OUT_HOLD: taken = status_i.out_hold;
      JC_NO_STEPS: taken = status_i.no_steps;
      default:     taken = 1'b1;
    endcase
    pc_d = taken ? word.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = word.op;

endmodule

@@ design/dose_stepper_sequencer.sv @@
// ----------------------------------------------------------------------------
// dose_stepper_sequencer: full-step stepper sequencer for a syringe dose
// Flow: one command at a time; the next transfer is taken once the result
//   has been loaded into the output register, even while it is stalled.
//   A start runs the serial divider for steps, step delay and progress
//   (progress only when the move has steps); a tick runs the progress
//   pass only, and none while no move with steps has been set up.
// Reset: asynchronous, active low; phase, step and delay counts, direction,
//   coils and done flag clear; plunger area returns to 300, step length to 1.
// ----------------------------------------------------------------------------
module dose_stepper_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [9:0]  dose_ml_i,
  input  logic        turn_direction_i,
  input  logic [15:0] flow_rate_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  coil_pattern_o,
  output logic [6:0]  progress_pct_o,
  output logic        busy_res_o,
  output logic        move_done_o
);
  import dss_pkg::*;

  // rate / 1000 for any 16-bit rate is (rate * 67109) >> 26, exact.
  localparam logic [32:0] RateRecip = 33'd67109;
  localparam int unsigned RateShift = 26;

  // The control store is walked by the sequencer; everything below is the
  // plain datapath that its micro-operations drive.
  dss_op_e     op;
  dss_status_t status;

  logic                div_start;
  logic [DivDendW-1:0] div_dividend;
  logic [DivSorW-1:0]  div_divisor;
  logic                div_busy;
  logic [DivDendW-1:0] div_quot;

  // Configuration registers.
  logic [15:0] area_q;
  logic [7:0]  slen_q;
  logic [15:0] area_eff;
  logic [7:0]  slen_eff;

  // Latched command.
  logic        func_q;
  logic [9:0]  dose_q;
  logic        dir_q;
  logic [15:0] rate_q;

  // Move state.
  logic [1:0]        phase_q, phase_d;
  logic [StepsW-1:0] steps_left_q, steps_total_q, steps_new_q;
  logic [DelayW-1:0] delay_reload_q, delay_left_q;
  logic              ccw_q;
  logic [3:0]        coil_q, coil_d;
  logic [6:0]        speed_q;
  logic [PctW-1:0]   pct_q;
  logic              done_q;

  // Output register.
  logic       out_valid_q;
  logic [3:0] out_coil_q;
  logic [6:0] out_pct_q;
  logic       out_busy_q;
  logic       out_done_q;

  logic        in_xfer;
  logic        out_hold;
  logic [32:0] rate_prod;
  logic [6:0]  speed_raw;
  logic [DelayW-1:0] delay_new;

  // A zero register is used as one.
  assign area_eff = (area_q == '0) ? 16'd1 : area_q;
  assign slen_eff = (slen_q == '0) ? 8'd1 : slen_q;

  assign in_stall_o = (op != OP_ACCEPT);
  assign in_xfer    = in_valid_i && (op == OP_ACCEPT);
  assign out_hold   = out_valid_q && out_stall_i;

  assign status.item_taken = in_xfer;
  assign status.tick_cmd   = (func_q == FuncTick);
  assign status.div_busy   = div_busy;
  assign status.out_hold   = out_hold;
  assign status.no_steps   = (steps_total_q == '0);

  dss_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  // Speed in whole mm/s, at least one.
  assign rate_prod = 33'(rate_q) * RateRecip;
  assign speed_raw = rate_prod[RateShift+6:RateShift];

  // The quotient of 1000 by a divisor of at least one never exceeds 1000.
  assign delay_new = (div_quot == '0) ? DelayW'(1) : div_quot[DelayW-1:0];

  // The shared divider serves three operand pairs, picked by the operation.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DivSorW'(1);
    unique case (op)
      OP_DIV_STEPS: begin
        div_start    = 1'b1;
        div_dividend = DivDendW'(dose_q * 20'd1000);
        div_divisor  = DivSorW'(area_eff * 24'(slen_eff));
      end
      OP_DIV_DELAY: begin
        div_start    = 1'b1;
        div_dividend = DivDendW'(1000);
        div_divisor  = DivSorW'(15'(slen_eff) * 15'(speed_q));
      end
      OP_DIV_PCT: begin
        div_start    = !status.no_steps;
        div_dividend = DivDendW'(steps_total_q - steps_left_q) * DivDendW'(100);
        div_divisor  = DivSorW'(steps_total_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  dss_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // Next coil drive: the very first drive keeps the phase, later ones step
  // it once in the direction of the move.
  always_comb begin
    phase_d = phase_q;
    if (coil_q != '0) begin
      phase_d = ccw_q ? phase_q + 2'd1 : phase_q - 2'd1;
    end
    unique case (phase_d)
      2'd0:    coil_d = 4'd3;
      2'd1:    coil_d = 4'd6;
      2'd2:    coil_d = 4'd12;
      default: coil_d = 4'd9;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q         <= 16'd300;
      slen_q         <= 8'd1;
      func_q         <= 1'b0;
      phase_q        <= '0;
      steps_left_q   <= '0;
      steps_total_q  <= '0;
      delay_reload_q <= '0;
      delay_left_q   <= '0;
      ccw_q          <= 1'b0;
      coil_q         <= '0;
      done_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegPlungerArea: area_q <= cfg_data_i;
          RegStepLength:  slen_q <= cfg_data_i[7:0];
          default:        area_q <= area_q;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (op)
        OP_ACCEPT: begin
          if (in_xfer) begin
            func_q <= func_i;
            done_q <= 1'b0;
          end
        end
        OP_START: begin
          delay_reload_q <= delay_new;
          ccw_q          <= dir_q;
          steps_total_q  <= steps_new_q;
          if (steps_new_q == '0) begin
            steps_left_q <= '0;
            delay_left_q <= '0;
          end else begin
            // First pattern goes out as soon as the move starts; ccw_q is
            // still the old direction here, so step with the new one.
            if (coil_q != '0) begin
              phase_q <= dir_q ? phase_q + 2'd1 : phase_q - 2'd1;
              unique case (dir_q ? phase_q + 2'd1 : phase_q - 2'd1)
                2'd0:    coil_q <= 4'd3;
                2'd1:    coil_q <= 4'd6;
                2'd2:    coil_q <= 4'd12;
                default: coil_q <= 4'd9;
              endcase
            end else begin
              coil_q <= coil_d;
            end
            steps_left_q <= steps_new_q - 1'b1;
            delay_left_q <= delay_new;
          end
        end
        OP_TICK: begin
          if (delay_left_q != '0) begin
            if (delay_left_q == DelayW'(1)) begin
              if (steps_left_q != '0) begin
                phase_q      <= phase_d;
                coil_q       <= coil_d;
                steps_left_q <= steps_left_q - 1'b1;
                delay_left_q <= delay_reload_q;
              end else begin
                delay_left_q <= '0;
                done_q       <= 1'b1;
              end
            end else begin
              delay_left_q <= delay_left_q - 1'b1;
            end
          end
        end
        OP_EMIT: begin
          out_valid_q <= 1'b1;
        end
        default: begin
          func_q <= func_q;
        end
      endcase
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dose_q <= dose_ml_i;
      dir_q  <= turn_direction_i;
      rate_q <= flow_rate_i;
    end
    if (op == OP_DIV_STEPS) begin
      speed_q <= (speed_raw == '0) ? 7'd1 : speed_raw;
    end
    if (op == OP_DIV_DELAY) begin
      steps_new_q <= div_quot[StepsW-1:0];
    end
    if (op == OP_DIV_PCT && status.no_steps) begin
      pct_q <= '0;
    end else if (op == OP_SAVE_PCT) begin
      pct_q <= div_quot[PctW-1:0];
    end
    if (op == OP_EMIT) begin
      out_coil_q <= coil_q;
      out_pct_q  <= pct_q;
      out_busy_q <= (steps_left_q != '0) || (delay_left_q != '0);
      out_done_q <= done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coil_pattern_o = out_coil_q;
  assign progress_pct_o = out_pct_q;
  assign busy_res_o     = out_busy_q;
  assign move_done_o    = out_done_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the dose stepper sequencer
// Sends start commands and millisecond ticks over the command channel. A
// scoreboard class predicts the coil pattern, progress, busy flag and
// move-done flag of every result and compares them with what the block
// returns. Plunger area and step length change between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module tb;
  import dss_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 2_000_000;
  // A safe margin for anything still in flight once the last result has come.
  localparam int unsigned DrainCycles = 150;

  localparam logic DIR_CW     = 1'b0;
  localparam logic DIR_CCW    = 1'b1;

  // One result of the block, as predicted or as seen on the outputs.
  typedef struct packed {
    logic [3:0]      coil;
    logic [PctW-1:0] pct;
    logic            busy;
    logic            done;
  } drive_rec_t;

  // Scoreboard: a copy of the sequencer's move state, the expected results
  // that are still waiting, and the mismatch count.
  class step_sequence_board;
    logic [15:0]       area_reg;
    logic [7:0]        slen_reg;
    logic [1:0]        phase;
    logic [StepsW-1:0] steps_left;
    logic [StepsW-1:0] steps_total;
    logic [DelayW-1:0] delay_reload;
    logic [DelayW-1:0] delay_left;
    logic              ccw;
    logic [3:0]        coil;
    drive_rec_t        pending_drives[$];
    int unsigned       mismatches;

    function new();
      area_reg     = 16'd300;
      slen_reg     = 8'd1;
      phase        = '0;
      steps_left   = '0;
      steps_total  = '0;
      delay_reload = '0;
      delay_left   = '0;
      ccw          = 1'b0;
      coil         = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == RegPlungerArea) begin
        area_reg = val;
      end else begin
        slen_reg = val[7:0];
      end
    endfunction

    // Drives the next full-step pattern. The very first drive after reset
    // uses the phase as it stands; later ones step it in the move direction.
    function void drive_coils();
      if (coil != 4'd0) begin
        phase = ccw ? phase + 2'd1 : phase - 2'd1;
      end
      case (phase)
        2'd0: coil = 4'd3;
        2'd1: coil = 4'd6;
        2'd2: coil = 4'd12;
        default: coil = 4'd9;
      endcase
    endfunction

    // Ticks still needed until the running move reports its end.
    function longint unsigned ticks_to_finish();
      return longint'(steps_left) * delay_reload + delay_left;
    endfunction

    function void note_command(logic f, logic [9:0] dose, logic dir, logic [15:0] rate);
      int unsigned       area_n;
      int unsigned       slen_n;
      int unsigned       steps_n;
      int unsigned       speed;
      int unsigned       dly;
      longint unsigned   pct;
      drive_rec_t        exp_rec;
      exp_rec.done = 1'b0;
      if (f == FuncStart) begin
        // A register holding zero acts as one.
        area_n  = (area_reg == 0) ? 1 : area_reg;
        slen_n  = (slen_reg == 0) ? 1 : slen_reg;
        steps_n = dose * 1000 / area_n / slen_n;
        speed   = rate / 1000;
        if (speed == 0) speed = 1;
        dly = 1000 / (slen_n * speed);
        if (dly == 0) dly = 1;
        delay_reload = DelayW'(dly);
        ccw          = dir;
        steps_total  = StepsW'(steps_n);
        if (steps_total == 0) begin
          // Nothing to move: the coils keep their pattern.
          steps_left = '0;
          delay_left = '0;
        end else begin
          drive_coils();
          steps_left = steps_total - 1'b1;
          delay_left = delay_reload;
        end
      end else if (delay_left != 0) begin
        delay_left = delay_left - 1'b1;
        if (delay_left == 0) begin
          if (steps_left != 0) begin
            drive_coils();
            steps_left = steps_left - 1'b1;
            delay_left = delay_reload;
          end else begin
            exp_rec.done = 1'b1;
          end
        end
      end
      pct = 0;
      if (steps_total != 0) begin
        pct = longint'(steps_total - steps_left) * 100 / steps_total;
      end
      exp_rec.coil = coil;
      exp_rec.pct  = PctW'(pct);
      exp_rec.busy = (steps_left != 0) || (delay_left != 0);
      pending_drives.push_back(exp_rec);
    endfunction

    function void check_drive(drive_rec_t got);
      drive_rec_t want;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: coil %0d pct %0d busy %0b done %0b",
                   got.coil, got.pct, got.busy, got.done);
        end
      end else begin
        want = pending_drives.pop_front();
        if (got.coil !== want.coil || got.pct !== want.pct ||
            got.busy !== want.busy || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"result mismatch: expected coil %0d pct %0d busy %0b done %0b,",
                      " got coil %0d pct %0d busy %0b done %0b"},
                     want.coil, want.pct, want.busy, want.done,
                     got.coil, got.pct, got.busy, got.done);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        func_i;
  logic [9:0]  dose_ml_i;
  logic        turn_direction_i;
  logic [15:0] flow_rate_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  coil_pattern_o;
  logic [6:0]  progress_pct_o;
  logic        busy_res_o;
  logic        move_done_o;

  step_sequence_board sb;
  int unsigned        burst_left;
  int unsigned        items_sent;
  int unsigned        cycle_count;

  dose_stepper_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .dose_ml_i        (dose_ml_i),
    .turn_direction_i (turn_direction_i),
    .flow_rate_i      (flow_rate_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .coil_pattern_o   (coil_pattern_o),
    .progress_pct_o   (progress_pct_o),
    .busy_res_o       (busy_res_o),
    .move_done_o      (move_done_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("dose_stepper_sequencer test failed");
      $finish;
    end
  end

  // Result monitor. Outputs are sampled at the rising edge, so the values seen
  // here are the ones the block presented during the transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_drive('{coil_pattern_o, progress_pct_o, busy_res_o, move_done_o});
    end
  end

  // Receiver: stalls follow a mode that is picked anew after each random span.
  // Mode 0 never stalls, mode 1 stalls half the time, mode 2 stalls most of
  // the time and mode 3 repeats a fixed pattern, so stalls fall on every
  // phase of the block's work.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = 1'($urandom_range(0, 1));
          2: out_stall_i = ($urandom_range(0, 3) != 0);
          default: out_stall_i = ((k % 7) < 3);
        endcase
      end
    end
  end

  // Offers one command at the falling edge and holds it until it is taken.
  // The sender works in bursts; between bursts valid may drop for a random gap.
  // On return valid is still high, so a back-to-back command just replaces
  // the payload at the next falling edge.
  task automatic push_command(input logic f, input logic [9:0] dose, input logic dir,
                              input logic [15:0] rate);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i       = 1'b1;
    func_i           = f;
    dose_ml_i        = dose;
    turn_direction_i = dir;
    flow_rate_i      = rate;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(f, dose, dir, rate);
    items_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // A tick carries random bits in the fields it does not use.
  task automatic push_tick();
    push_command(FuncTick, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                 16'($urandom_range(0, 65535)));
  endtask

  // Lets every expected result arrive and the block go quiet, so that the
  // registers can be written safely.
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.pending_drives.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  initial begin
    int unsigned       area_set[7];
    int unsigned       slen_set[7];
    int unsigned       target;
    int unsigned       n;
    int unsigned       kind;
    int unsigned       p;
    longint unsigned   rem;
    logic [9:0]        dose;
    logic [15:0]       rate;

    sb               = new();
    burst_left       = 0;
    items_sent       = 0;
    cycle_count      = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = RegPlungerArea;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    func_i           = FuncTick;
    dose_ml_i        = '0;
    turn_direction_i = DIR_CW;
    flow_rate_i      = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, registers at their reset values. First a tick with no
    // move set up, then a start with no steps while the coils are still off,
    // then a start with every field at its maximum (first drive keeps phase
    // zero), a start that drops the running move, a few ticks and a start
    // with no steps while a move is running.
    push_tick();
    push_command(FuncStart, 10'd0, DIR_CW, 16'd0);
    push_command(FuncStart, 10'd1023, DIR_CCW, 16'hFFFF);
    push_command(FuncStart, 10'd1, DIR_CW, 16'd1000);
    repeat (3) push_tick();
    push_command(FuncStart, 10'd0, DIR_CCW, 16'd12345);
    push_tick();

    // Short moves with a one-millisecond step delay: four steps each way,
    // run to the end so that the move-done flag shows and the phase wraps.
    settle();
    write_reg(RegPlungerArea, 16'd1000);
    write_reg(RegStepLength, 16'd255);
    push_command(FuncStart, 10'd1023, DIR_CCW, 16'hFFFF);
    repeat (6) push_tick();
    push_command(FuncStart, 10'd1023, DIR_CW, 16'd4000);
    repeat (5) push_tick();

    // Both registers at zero, which the block treats as one.
    settle();
    write_reg(RegPlungerArea, 16'd0);
    write_reg(RegStepLength, 16'd0);
    push_command(FuncStart, 10'd1, DIR_CW, 16'hFFFF);
    push_tick();

    // Random part: several register settings, extremes among them. Most of
    // each phase is well-formed moves, many of them ticked to the end, the
    // rest interrupted moves and stray ticks.
    area_set = '{1000, 65535, 1, 250, 0, $urandom_range(1, 2000), 300};
    slen_set = '{255, 255, 1, 100, 0, $urandom_range(1, 255), 1};
    for (p = 0; p < 7; p++) begin
      settle();
      write_reg(RegPlungerArea, 16'(area_set[p]));
      write_reg(RegStepLength, 16'(slen_set[p]));
      target = items_sent + 135;
      while (items_sent < target) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          repeat ($urandom_range(1, 3)) push_tick();
        end else begin
          if ($urandom_range(0, 1) != 0) begin
            dose = 10'($urandom_range(0, 1023));
          end else begin
            dose = 10'($urandom_range(0, 20));
          end
          case ($urandom_range(0, 4))
            0, 1: rate = 16'($urandom_range(0, 65535));
            2, 3: rate = 16'($urandom_range(20000, 65535));
            default: rate = 16'($urandom_range(0, 999));
          endcase
          push_command(FuncStart, dose, 1'($urandom_range(0, 1)), rate);
          rem = sb.ticks_to_finish();
          if (rem <= 80 && $urandom_range(0, 9) < 7) begin
            n = 32'(rem) + $urandom_range(0, 2);
          end else begin
            n = $urandom_range(0, 20);
          end
          repeat (n) push_tick();
        end
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.pending_drives.size() == 0) begin
      $display("dose_stepper_sequencer test passed");
    end else begin
      $display("dose_stepper_sequencer test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/dss_pkg.sv
design/dss_divider.sv
design/dss_sequencer.sv
design/dose_stepper_sequencer.sv
bench/tb.sv
